[hw/rtl/round_robin_task_scheduler_macros.svh]
// assertion macros for the scheduler checker
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define RRTS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/rrts_pkg.sv]
package rrts_pkg;

  localparam int MaxTasks = 16;
  localparam int SlotW = $clog2(MaxTasks);
  localparam int CountW = $clog2(MaxTasks + 1);

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_SWITCH  = 3'd1;
  localparam logic [2:0] OP_BLOCK   = 3'd2;
  localparam logic [2:0] OP_UNBLOCK = 3'd3;
  localparam logic [2:0] OP_SLEEP   = 3'd4;
  localparam logic [2:0] OP_REMOVE  = 3'd5;
  localparam logic [2:0] OP_FIND    = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FAIL     = 2'd3;

  typedef struct packed {
    logic              capture;
    logic              do_single;
    logic              age;
    logic              shift;
    logic [SlotW-1:0]  idx;
    logic              finish;
    logic [1:0]        st;
    logic [SlotW-1:0]  res_slot;
    logic              res_priv;
    logic              sel;
    logic              remove_done;
    logic              first_clr;
  } rrts_cmd_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [CountW-1:0] count;
    logic [SlotW-1:0]  next_slot;
    logic [SlotW-1:0]  running_slot;
    logic              first_switch;
    logic              ready_hit;
    logic              pid_hit;
    logic              slot_ok;
    logic              kind_at;
    logic [SlotW-1:0]  slot;
  } rrts_stat_t;

endpackage

[hw/rtl/rrts_datapath.sv]
module rrts_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [19:0]              tick_delay_us,
  input  logic [2:0]               opcode,
  input  logic                     task_kind,
  input  logic [3:0]               slot,
  input  logic [15:0]              pid,
  input  logic [31:0]              duration_us,
  input  rrts_pkg::rrts_cmd_t      cmd,
  output rrts_pkg::rrts_stat_t     stat,
  output logic [1:0]               status,
  output logic [3:0]               chosen_slot,
  output logic [15:0]              chosen_pid,
  output logic                     privilege_change
);
  import rrts_pkg::*;

  logic [MaxTasks-1:0] kind_table;
  logic [MaxTasks-1:0] blocked_table;
  logic [31:0]         sleep_table [MaxTasks];
  logic [15:0]         pid_table [MaxTasks];
  logic [CountW-1:0]   task_count;
  logic [SlotW-1:0]    next_slot;
  logic [SlotW-1:0]    running_slot;
  logic                first_switch;
  logic [15:0]         pid_counter;
  logic [2:0]          op_q;
  logic                kind_q;
  logic [3:0]          slot_q;
  logic [15:0]         pid_q;
  logic [31:0]         dur_q;
  logic [SlotW-1:0]    idx_p1;
  logic [SlotW-1:0]    wrap_next;
  logic [31:0]         aged;

  assign idx_p1 = cmd.idx + SlotW'(1);
  assign wrap_next = ({1'b0, cmd.res_slot} + CountW'(1) >= task_count) ? '0
                     : cmd.res_slot + SlotW'(1);
  assign aged = (sleep_table[cmd.idx] >= {12'd0, tick_delay_us})
                ? sleep_table[cmd.idx] - {12'd0, tick_delay_us} : 32'd0;

  always_comb begin
    stat.op = op_q;
    stat.count = task_count;
    stat.next_slot = next_slot;
    stat.running_slot = running_slot;
    stat.first_switch = first_switch;
    stat.ready_hit = !blocked_table[cmd.idx] && sleep_table[cmd.idx] == 32'd0;
    stat.pid_hit = pid_table[cmd.idx] == pid_q;
    stat.slot_ok = {1'b0, slot_q} < task_count;
    stat.kind_at = kind_table[cmd.idx];
    stat.slot = slot_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind_table <= '0;
      blocked_table <= '0;
      for (int i = 0; i < MaxTasks; i++) begin
        sleep_table[i] <= 32'd0;
      end
      task_count <= '0;
      next_slot <= '0;
      running_slot <= '0;
      first_switch <= 1'b1;
      pid_counter <= '0;
    end else begin
      if (cmd.capture) begin
        op_q <= opcode;
        kind_q <= task_kind;
        slot_q <= slot;
        pid_q <= pid;
        dur_q <= duration_us;
      end
      if (cmd.age) begin
        sleep_table[cmd.idx] <= aged;
      end
      if (cmd.shift) begin
        kind_table[cmd.idx] <= kind_table[idx_p1];
        blocked_table[cmd.idx] <= blocked_table[idx_p1];
        sleep_table[cmd.idx] <= sleep_table[idx_p1];
        pid_table[cmd.idx] <= pid_table[idx_p1];
      end
      if (cmd.do_single) begin
        unique case (op_q)
          OP_ADD: begin
            kind_table[cmd.idx] <= kind_q;
            blocked_table[cmd.idx] <= 1'b0;
            sleep_table[cmd.idx] <= 32'd0;
            pid_table[cmd.idx] <= pid_counter + 16'd1;
          end
          OP_BLOCK: blocked_table[cmd.idx] <= 1'b1;
          OP_UNBLOCK: blocked_table[cmd.idx] <= 1'b0;
          OP_SLEEP: sleep_table[cmd.idx] <= dur_q;
          default: begin
          end
        endcase
      end
      if (cmd.finish) begin
        status <= cmd.st;
        chosen_slot <= (cmd.st == ST_OK) ? 4'(cmd.res_slot) : 4'd0;
        if (cmd.st != ST_OK) begin
          chosen_pid <= 16'd0;
        end else if (op_q == OP_ADD) begin
          chosen_pid <= pid_counter + 16'd1;
        end else begin
          chosen_pid <= pid_table[cmd.res_slot];
        end
        privilege_change <= (cmd.st == ST_OK) && cmd.res_priv;
      end
      if (cmd.do_single && op_q == OP_ADD) begin
        pid_counter <= pid_counter + 16'd1;
        task_count <= task_count + CountW'(1);
      end
      if (cmd.first_clr) begin
        first_switch <= 1'b0;
      end
      if (cmd.sel) begin
        running_slot <= cmd.res_slot;
        next_slot <= wrap_next;
      end
      if (cmd.remove_done) begin
        task_count <= task_count - CountW'(1);
        first_switch <= 1'b1;
        next_slot <= '0;
        running_slot <= '0;
      end
    end
  end
endmodule

[hw/rtl/rrts_ctrl.sv]
module rrts_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 tick,
  input  rrts_pkg::rrts_stat_t stat,
  output rrts_pkg::rrts_cmd_t  cmd
);
  import rrts_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_AGE, S_PICK, S_SHIFT, S_FIND} state_t;

  state_t            state;
  logic [SlotW-1:0]  idx;
  logic [CountW-1:0] tries;
  logic [CountW-1:0] idx_ext;
  logic [CountW-1:0] idx_p1;

  assign idx_ext = {1'b0, idx};
  assign idx_p1 = idx_ext + CountW'(1);
  assign in_stall = state != S_IDLE || (out_valid && out_stall);

  always_comb begin
    cmd = '0;
    cmd.idx = idx;
    cmd.capture = state == S_IDLE && in_valid && !in_stall;
    cmd.res_slot = idx;
    cmd.st = ST_FAIL;
    unique case (state)
      S_IDLE: begin
      end
      S_DECODE: begin
        cmd.idx = SlotW'(stat.count);
        case (stat.op)
          OP_ADD: begin
            cmd.finish = 1'b1;
            if (stat.count >= CountW'(MaxTasks)) begin
              cmd.st = ST_FULL;
            end else begin
              cmd.do_single = 1'b1;
              cmd.st = ST_OK;
              cmd.res_slot = SlotW'(stat.count);
            end
          end
          OP_BLOCK, OP_UNBLOCK, OP_SLEEP: begin
            cmd.finish = 1'b1;
            cmd.idx = stat.slot;
            if (stat.slot_ok) begin
              cmd.do_single = 1'b1;
              cmd.st = ST_OK;
              cmd.res_slot = stat.slot;
            end
          end
          OP_REMOVE: begin
            if (stat.count <= CountW'(1)) begin
              cmd.finish = 1'b1;
            end else begin
              cmd.finish = 1'b1;
              cmd.st = ST_OK;
              cmd.res_slot = stat.running_slot;
            end
          end
          OP_SWITCH, OP_FIND: begin
            if (stat.count == '0) begin
              cmd.finish = 1'b1;
              if (stat.op == OP_FIND) begin
                cmd.st = ST_NOTFOUND;
              end
            end
          end
          default: cmd.finish = 1'b1;
        endcase
      end
      S_AGE: cmd.age = 1'b1;
      S_PICK: begin
        if (stat.first_switch || stat.count == CountW'(1) || stat.ready_hit) begin
          cmd.finish = 1'b1;
          cmd.st = ST_OK;
          cmd.res_priv = stat.kind_at;
          cmd.sel = 1'b1;
          cmd.first_clr = 1'b1;
        end else if (tries + CountW'(1) >= stat.count) begin
          cmd.finish = 1'b1;
        end
      end
      S_SHIFT: begin
        if (idx_p1 < stat.count) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.remove_done = 1'b1;
        end
      end
      S_FIND: begin
        if (stat.pid_hit) begin
          cmd.finish = 1'b1;
          cmd.st = ST_OK;
        end else if (idx_p1 >= stat.count) begin
          cmd.finish = 1'b1;
          cmd.st = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      idx <= '0;
      tries <= '0;
    end else begin
      if (cmd.finish && state != S_SHIFT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          tries <= '0;
          if (cmd.finish) begin
            state <= (stat.op == OP_REMOVE && cmd.st == ST_OK) ? S_SHIFT : S_IDLE;
            idx <= stat.running_slot;
          end else if (stat.op == OP_FIND) begin
            state <= S_FIND;
            idx <= '0;
          end else if (tick) begin
            state <= S_AGE;
            idx <= '0;
          end else begin
            state <= S_PICK;
            idx <= (stat.next_slot < stat.count[SlotW-1:0] || stat.count[SlotW])
                   ? stat.next_slot : '0;
          end
        end
        S_AGE: begin
          if (idx_p1 >= stat.count) begin
            state <= S_PICK;
            idx <= ({1'b0, stat.next_slot} < stat.count) ? stat.next_slot : '0;
          end else begin
            idx <= idx_p1[SlotW-1:0];
          end
        end
        S_PICK: begin
          if (cmd.finish) begin
            state <= S_IDLE;
          end else begin
            tries <= tries + CountW'(1);
            idx <= (idx_p1 >= stat.count) ? '0 : idx_p1[SlotW-1:0];
          end
        end
        S_SHIFT: begin
          if (cmd.remove_done) begin
            state <= S_IDLE;
          end else begin
            idx <= idx_p1[SlotW-1:0];
          end
        end
        S_FIND: begin
          if (cmd.finish) begin
            state <= S_IDLE;
          end else begin
            idx <= idx_p1[SlotW-1:0];
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/round_robin_task_scheduler.sv]
// round-robin task scheduler over a table of 16 tasks
// input channel: in_valid/in_stall with opcode, task_kind, slot, pid,
//   duration_us and is_timer_tick; one transfer is one operation
// output channel: out_valid/out_stall with status, chosen_slot, chosen_pid
//   and privilege_change; each operation gives exactly one result
// configuration: cfg_valid/cfg_ready writes tick_delay_us (reset 1000)
// sequence: add, block, unblock, sleep, bad opcodes and an empty table are
//   answered from decode; find walks the table from entry 0 to the hit or
//   the end; remove gives its result from decode and the next operation
//   waits while later entries move down; switch first ages every entry
//   (on a timer tick) and then probes entries in round-robin order for a
//   ready task
// the table is walked one entry a cycle by the sequencer; one operation is
//   in flight at a time
// reset clears the kind, blocked and sleep entries, the counters and the first-switch flag
// a result waits in the output register while out_stall is high; the next
//   operation is not taken until the result has been transferred
module round_robin_task_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic        task_kind,
  input  logic [3:0]  slot,
  input  logic [15:0] pid,
  input  logic [31:0] duration_us,
  input  logic        is_timer_tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  chosen_slot,
  output logic [15:0] chosen_pid,
  output logic        privilege_change,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data
);
  import rrts_pkg::*;

  rrts_cmd_t  cmd;
  rrts_stat_t stat;
  logic [19:0] tick_delay_us;
  logic        tick_q;
  rrts_cmd_t   cmd_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_delay_us <= 20'd1000;
    end else if (cfg_valid && cfg_ready) begin
      tick_delay_us <= cfg_data;
    end
    if (cmd_ctl.capture) begin
      tick_q <= is_timer_tick;
    end
  end

  always_comb begin
    cmd = cmd_ctl;
  end

  rrts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .tick(tick_q),
    .stat(stat), .cmd(cmd_ctl)
  );

  rrts_datapath u_dp (
    .clk(clk), .rst(rst), .tick_delay_us(tick_delay_us), .opcode(opcode),
    .task_kind(task_kind), .slot(slot), .pid(pid), .duration_us(duration_us),
    .cmd(cmd), .stat(stat), .status(status), .chosen_slot(chosen_slot),
    .chosen_pid(chosen_pid), .privilege_change(privilege_change)
  );
endmodule

[hw/rtl/round_robin_task_scheduler_checker.sv]
`include "round_robin_task_scheduler_macros.svh"
module round_robin_task_scheduler_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [3:0]  chosen_slot,
  input logic [15:0] chosen_pid,
  input logic        privilege_change
);
  import rrts_pkg::*;

  `RRTS_ASSERT_IMPL(a_fail_zero, clk, rst, out_valid && status != ST_OK,
    chosen_slot == 4'd0 && chosen_pid == 16'd0 && !privilege_change)
  `RRTS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(status) && $stable(chosen_pid))
  `RRTS_ASSERT_NEXT(a_one_busy, clk, rst, in_valid && !in_stall, in_stall)
endmodule

bind round_robin_task_scheduler round_robin_task_scheduler_checker u_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .chosen_slot(chosen_slot), .chosen_pid(chosen_pid),
  .privilege_change(privilege_change)
);

[test/tb_round_robin_task_scheduler.sv]
`default_nettype none

module tb_round_robin_task_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import rrts_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int RandItems = 1080;

  typedef struct packed {
    logic [1:0]  st;
    logic [3:0]  sl;
    logic [15:0] pd;
    logic        pv;
  } sched_res_t;

  typedef struct packed {
    logic [2:0]  op;
    logic        kind;
    logic [3:0]  sl;
    logic [15:0] pd;
    logic [31:0] dur;
    logic        tick;
    logic        typed;
    sched_res_t  res;
  } op_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  opcode = '0;
  logic        task_kind = 1'b0;
  logic [3:0]  slot = '0;
  logic [15:0] pid = '0;
  logic [31:0] duration_us = '0;
  logic        is_timer_tick = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [3:0]  chosen_slot;
  logic [15:0] chosen_pid;
  logic        privilege_change;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [19:0] cfg_data = '0;

  round_robin_task_scheduler i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .task_kind        (task_kind),
    .slot             (slot),
    .pid              (pid),
    .duration_us      (duration_us),
    .is_timer_tick    (is_timer_tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .chosen_slot      (chosen_slot),
    .chosen_pid       (chosen_pid),
    .privilege_change (privilege_change),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  // scheduler mirror
  logic        kind_m [MaxTasks];
  logic        blocked_m [MaxTasks];
  logic [31:0] sleep_m [MaxTasks];
  logic [15:0] pid_m [MaxTasks];
  int          count_m;
  int          next_m;
  int          running_m;
  bit          first_m;
  logic [15:0] pid_ctr_m;
  logic [19:0] tick_m;

  sched_res_t  pending_q[$];
  int          errors = 0;
  bit          sender_idle = 1'b1;
  bit          sink_idle = 1'b1;
  bit          long_hold = 1'b0;

  task automatic note_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic sched_res_t hit(input int s, input logic pv);
    sched_res_t r;
    r.st = ST_OK;
    r.sl = s[3:0];
    r.pd = pid_m[s];
    r.pv = pv;
    return r;
  endfunction

  function automatic sched_res_t schedule_op(input logic [2:0] op, input logic kind,
                                             input logic [3:0] sl, input logic [15:0] pd,
                                             input logic [31:0] dur, input logic tick);
    sched_res_t miss;
    int cur;
    int tries;
    int r;
    miss = '{st: ST_FAIL, sl: '0, pd: '0, pv: 1'b0};
    case (op)
      OP_ADD: begin
        if (count_m >= MaxTasks) begin
          miss.st = ST_FULL;
          return miss;
        end
        pid_ctr_m++;
        kind_m[count_m] = kind;
        blocked_m[count_m] = 1'b0;
        sleep_m[count_m] = '0;
        pid_m[count_m] = pid_ctr_m;
        count_m++;
        return hit(count_m - 1, 1'b0);
      end
      OP_SWITCH: begin
        if (count_m == 0) return miss;
        if (tick) begin
          for (int i = 0; i < count_m; i++)
            sleep_m[i] = (sleep_m[i] >= 32'(tick_m)) ? sleep_m[i] - 32'(tick_m) : '0;
        end
        cur = (next_m < count_m) ? next_m : 0;
        if (first_m) begin
          first_m = 1'b0;
        end else if (count_m > 1) begin
          tries = 0;
          while (blocked_m[cur] || sleep_m[cur] != 0) begin
            tries++;
            if (tries >= count_m) return miss;
            cur = (cur + 1 >= count_m) ? 0 : cur + 1;
          end
        end
        running_m = cur;
        next_m = (cur + 1 >= count_m) ? 0 : cur + 1;
        return hit(cur, kind_m[cur]);
      end
      OP_BLOCK, OP_UNBLOCK, OP_SLEEP: begin
        if (int'(sl) >= count_m) return miss;
        if (op == OP_BLOCK) blocked_m[sl] = 1'b1;
        else if (op == OP_UNBLOCK) blocked_m[sl] = 1'b0;
        else sleep_m[sl] = dur;
        return hit(sl, 1'b0);
      end
      OP_REMOVE: begin
        r = running_m;
        if (count_m <= 1 || r >= count_m) return miss;
        miss = hit(r, 1'b0);
        for (int i = r; i + 1 < count_m; i++) begin
          kind_m[i] = kind_m[i + 1];
          blocked_m[i] = blocked_m[i + 1];
          sleep_m[i] = sleep_m[i + 1];
          pid_m[i] = pid_m[i + 1];
        end
        count_m--;
        first_m = 1'b1;
        next_m = 0;
        running_m = 0;
        return miss;
      end
      OP_FIND: begin
        for (int i = 0; i < count_m; i++)
          if (pid_m[i] == pd) return hit(i, 1'b0);
        miss.st = ST_NOTFOUND;
        return miss;
      end
      default: return miss;
    endcase
  endfunction

  task automatic send_op(input op_row_t row);
    sched_res_t res;
    in_valid <= 1'b1;
    opcode <= row.op;
    task_kind <= row.kind;
    slot <= row.sl;
    pid <= row.pd;
    duration_us <= row.dur;
    is_timer_tick <= row.tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = schedule_op(row.op, row.kind, row.sl, row.pd, row.dur, row.tick);
    pending_q.push_back(row.typed ? row.res : res);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic drain_results;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_tick(input logic [19:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tick_m = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic op_row_t plain(input logic [2:0] op, input logic kind, input logic [3:0] sl,
                                    input logic [15:0] pd, input logic [31:0] dur,
                                    input logic tick);
    return '{op: op, kind: kind, sl: sl, pd: pd, dur: dur, tick: tick, typed: 1'b0, res: '0};
  endfunction

  function automatic op_row_t typed(input op_row_t row, input logic [1:0] st,
                                    input logic [3:0] sl, input logic [15:0] pd,
                                    input logic pv);
    row.typed = 1'b1;
    row.res = '{st: st, sl: sl, pd: pd, pv: pv};
    return row;
  endfunction

  function automatic op_row_t random_op;
    op_row_t row;
    int r;
    row = plain(OP_FIND, $urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 65535),
                $urandom, $urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 20) row.op = OP_ADD;
    else if (r < 48) row.op = OP_SWITCH;
    else if (r < 58) row.op = OP_BLOCK;
    else if (r < 68) row.op = OP_UNBLOCK;
    else if (r < 78) row.op = OP_SLEEP;
    else if (r < 88) row.op = OP_REMOVE;
    else if (r < 98) row.op = OP_FIND;
    else row.op = OP_UNUSED;
    if (count_m > 0 && $urandom_range(0, 9) < 8) row.sl = $urandom_range(0, count_m - 1);
    if (count_m > 0 && $urandom_range(0, 9) < 6) row.pd = pid_m[$urandom_range(0, count_m - 1)];
    if ($urandom_range(0, 9) < 7) row.dur = $urandom_range(0, 3000);
    return row;
  endfunction

  always @(posedge clk) begin
    sched_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        note_mismatch("result transfer with nothing expected");
      end else begin
        e = pending_q.pop_front();
        if (status !== e.st)
          note_mismatch($sformatf("status %0d, expected %0d", status, e.st));
        if (chosen_slot !== e.sl)
          note_mismatch($sformatf("chosen_slot %0d, expected %0d", chosen_slot, e.sl));
        if (chosen_pid !== e.pd)
          note_mismatch($sformatf("chosen_pid %0d, expected %0d", chosen_pid, e.pd));
        if (privilege_change !== e.pv)
          note_mismatch($sformatf("privilege_change %0b, expected %0b", privilege_change, e.pv));
      end
    end
  end

  // result side stall pattern
  initial begin
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
        @(posedge clk);
      end else if (!sink_idle) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  initial begin
    op_row_t dir_rows[$];
    for (int i = 0; i < MaxTasks; i++) begin
      kind_m[i] = 1'b0;
      blocked_m[i] = 1'b0;
      sleep_m[i] = '0;
      pid_m[i] = '0;
    end
    count_m = 0;
    next_m = 0;
    running_m = 0;
    first_m = 1'b1;
    pid_ctr_m = '0;
    tick_m = 20'd1000;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir_rows.push_back(typed(plain(OP_SWITCH, 0, 0, 0, 0, 1), ST_FAIL, 0, 0, 0));
    dir_rows.push_back(typed(plain(OP_REMOVE, 0, 0, 0, 0, 0), ST_FAIL, 0, 0, 0));
    dir_rows.push_back(typed(plain(OP_FIND, 0, 0, 16'h0000, 0, 0), ST_NOTFOUND, 0, 0, 0));
    dir_rows.push_back(typed(plain(OP_BLOCK, 0, 0, 0, 0, 0), ST_FAIL, 0, 0, 0));
    dir_rows.push_back(typed(plain(OP_UNUSED, 1, 15, 16'hffff, '1, 1), ST_FAIL, 0, 0, 0));
    dir_rows.push_back(typed(plain(OP_ADD, 0, 0, 0, 0, 0), ST_OK, 0, 1, 0));
    dir_rows.push_back(typed(plain(OP_SWITCH, 0, 0, 0, 0, 1), ST_OK, 0, 1, 0));
    dir_rows.push_back(typed(plain(OP_SWITCH, 0, 0, 0, 0, 0), ST_OK, 0, 1, 0));
    dir_rows.push_back(typed(plain(OP_ADD, 1, 0, 0, 0, 0), ST_OK, 1, 2, 0));
    dir_rows.push_back(typed(plain(OP_SWITCH, 0, 0, 0, 0, 0), ST_OK, 0, 1, 0));
    dir_rows.push_back(typed(plain(OP_SLEEP, 0, 1, 0, 32'hffff_ffff, 0), ST_OK, 1, 2, 0));
    dir_rows.push_back(typed(plain(OP_BLOCK, 0, 0, 0, 0, 0), ST_OK, 0, 1, 0));
    dir_rows.push_back(typed(plain(OP_SWITCH, 0, 0, 0, 0, 1), ST_FAIL, 0, 0, 0));
    dir_rows.push_back(typed(plain(OP_UNBLOCK, 0, 15, 0, 0, 0), ST_FAIL, 0, 0, 0));
    dir_rows.push_back(typed(plain(OP_UNBLOCK, 0, 0, 0, 0, 0), ST_OK, 0, 1, 0));
    dir_rows.push_back(plain(OP_SWITCH, 0, 0, 0, 0, 1));
    dir_rows.push_back(typed(plain(OP_FIND, 0, 0, 16'd2, 0, 0), ST_OK, 1, 2, 0));
    dir_rows.push_back(typed(plain(OP_FIND, 0, 0, 16'hffff, 0, 0), ST_NOTFOUND, 0, 0, 0));
    dir_rows.push_back(plain(OP_SLEEP, 0, 1, 0, 32'd1500, 0));
    dir_rows.push_back(plain(OP_SWITCH, 0, 0, 0, 0, 1));
    dir_rows.push_back(plain(OP_SWITCH, 0, 0, 0, 0, 1));
    dir_rows.push_back(plain(OP_REMOVE, 0, 0, 0, 0, 0));
    dir_rows.push_back(plain(OP_SWITCH, 0, 0, 0, 0, 0));
    dir_rows.push_back(typed(plain(OP_REMOVE, 0, 0, 0, 0, 0), ST_FAIL, 0, 0, 0));
    foreach (dir_rows[i]) send_op(dir_rows[i]);
    // fill the table up to the full report
    while (count_m < MaxTasks) send_op(plain(OP_ADD, $urandom_range(0, 1), 0, 0, 0, 0));
    send_op(typed(plain(OP_ADD, 1, 0, 0, 0, 0), ST_FULL, 0, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      in_valid <= 1'b0;
      case (ph)
        0: write_tick(20'd0);
        1: write_tick(20'd1_000_000);
        2: write_tick(20'($urandom_range(1, 1_000_000)));
        default: write_tick(20'd1);
      endcase
      if (ph == 3) begin
        sender_idle = 1'b0;
        sink_idle = 1'b0;
      end
      for (int n = 0; n < RandItems / 4; n++) begin
        if (ph == 1 && n == 100) long_hold = 1'b1;
        if (ph == 2 && n == 50) begin
          in_valid <= 1'b0;
          while (pending_q.size() != 0) @(posedge clk);
        end
        send_op(random_op());
      end
    end
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("round_robin_task_scheduler verification clean");
    else $display("round_robin_task_scheduler verification failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("round_robin_task_scheduler verification failed");
    $finish;
  end

endmodule

`default_nettype wire
